FILE: rtl/core/sha256_pkg.sv
// shared constants and round helpers for the sha-256 stream hash
package sha256_pkg;

    localparam int unsigned RoundCount = 64;

    typedef logic [31:0] t_word;

    function automatic t_word round_const(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word initial_hash(input logic [2:0] idx);
        t_word h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // control from the sequencer to the round unit
    typedef struct packed {
        logic       load;     // copy chaining value into a..h
        logic       round;    // run one round
        logic [5:0] rnd;      // round number
        logic       fold;     // add a..h into chaining value
        logic       reinit;   // back to initial hash
    } t_core_ctl;

endpackage

FILE: rtl/core/sha256_round.sv
// one sha-256 round per cycle, with rolling schedule and chaining value
module sha256_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_core_ctl i_ctl,
    input  sha256_pkg::t_word     i_msg_word,
    input  logic [2:0]            i_hash_sel,
    output sha256_pkg::t_word     o_hash_word
);
    sha256_pkg::t_word r_h [8];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_w [16];
    sha256_pkg::t_word w, s0, s1, e1, a0, ch, mj, t1, t2;

    always_comb begin
        s0 = sha256_pkg::rotr(r_w[1], 7) ^ sha256_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha256_pkg::rotr(r_w[14], 17) ^ sha256_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w  = (i_ctl.rnd < 6'd16) ? i_msg_word : r_w[0] + s0 + r_w[9] + s1;
        e1 = sha256_pkg::rotr(r_v[4], 6) ^ sha256_pkg::rotr(r_v[4], 11)
           ^ sha256_pkg::rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + e1 + ch + sha256_pkg::round_const(i_ctl.rnd) + w;
        a0 = sha256_pkg::rotr(r_v[0], 2) ^ sha256_pkg::rotr(r_v[0], 13)
           ^ sha256_pkg::rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = a0 + mj;
    end

    assign o_hash_word = r_h[i_hash_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::initial_hash(3'(i));
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            // window shifts so w[t-16] sits at the bottom
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w;
        end
    end
endmodule

FILE: rtl/core/sha256_stream_hash.sv
// top level of the byte-stream sha-256 hash
// s_axis carries message bytes: tdata[7:0] data_byte, tuser[0] byte_valid, tlast
// marks the end of the message. m_axis carries the digest: tdata[31:0]
// digest_word, tuser[2:0] word_index, tlast on word 7.
// bytes are taken one per cycle while the 64-byte block fills; the 64th byte
// starts a compression (load, 64 rounds on the shared round unit, fold) during
// which s_axis_tready is low. the last transfer adds padding: a
// fill of the rest of the block at one byte per cycle, one or two compressions,
// then the eight digest words, one per accepted output cycle. the output has a
// register; a stalled receiver holds the current word and the block waits.
// after the eighth word the block is back at its initial hash and takes the
// next message. synchronous active-low reset clears the position, length and
// chaining value; the block buffer needs no clearing, every byte is written
// before it is read.
module sha256_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT
    } t_state;

    t_state     r_state;
    logic [5:0] r_pos;
    logic [63:0] r_bits;
    logic [5:0] r_rnd;
    logic       r_final;  // padding pass in progress
    logic       r_len;    // length goes into this block
    logic       r_pad80;  // next pad slot holds 0x80
    logic [2:0] r_oidx;
    logic       r_ovalid;
    logic [23:0] r_acc;
    sha256_pkg::t_word        r_blk [16];
    sha256_pkg::t_word        msg_word;
    sha256_pkg::t_word        hash_word;
    sha256_pkg::t_core_ctl    ctl;
    logic       take, last_byte;
    logic       byte_wr;
    logic [7:0] byte_val;

    assign s_axis_tready = (r_state == S_IDLE);
    assign take = s_axis_tvalid && s_axis_tready;
    // block words shift out at the bottom, one per round for the first 16 rounds
    assign msg_word = r_blk[0];

    always_comb begin
        ctl.load   = (r_state == S_LOAD);
        ctl.round  = (r_state == S_ROUND);
        ctl.rnd    = r_rnd;
        ctl.fold   = (r_state == S_FOLD);
        ctl.reinit = (r_state == S_OUT) && m_axis_tready && r_ovalid && (r_oidx == 3'd7);
    end

    sha256_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_msg_word(msg_word), .i_hash_sel(r_oidx), .o_hash_word(hash_word)
    );

    assign last_byte = (r_pos == 6'd63);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = hash_word;
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);

    // byte written into the block this cycle, from input or padding
    always_comb begin
        byte_wr  = 1'b0;
        byte_val = 8'h00;
        if (take && s_axis_tuser) begin
            byte_wr  = 1'b1;
            byte_val = s_axis_tdata;
        end else if (take && s_axis_tlast) begin
            byte_wr  = 1'b1;
            byte_val = 8'h80;
        end else if (r_state == S_PAD) begin
            byte_wr = 1'b1;
            if (r_pad80)
                byte_val = 8'h80;
            else if (r_len && r_pos >= 6'd56)
                byte_val = r_bits[6'd63 - {r_pos[2:0], 3'd0} -: 8];
        end
    end

    // block buffer: bytes gather into a word, whole words shift in
    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            r_acc <= {r_acc[15:0], byte_val};
        end
        if ((byte_wr && r_pos[1:0] == 2'd3) || (r_state == S_ROUND && r_rnd < 6'd16)) begin
            for (int i = 0; i < 15; i++) r_blk[i] <= r_blk[i+1];
            r_blk[15] <= {r_acc, byte_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_bits   <= '0;
            r_rnd    <= '0;
            r_final  <= 1'b0;
            r_len    <= 1'b0;
            r_pad80  <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rnd <= '0;
                    if (take && s_axis_tuser) begin
                        r_bits <= r_bits + 64'd8;
                        r_pos  <= r_pos + 6'd1;
                        r_pad80 <= s_axis_tlast;
                        if (last_byte) begin
                            r_state <= S_LOAD;
                            r_final <= s_axis_tlast;
                            r_len   <= 1'b0;
                        end else if (s_axis_tlast) begin
                            // 0x80 lands after the byte, in the next cycle's pad slot
                            r_final <= 1'b1;
                            r_len   <= (r_pos < 6'd55);
                            r_state <= S_PAD;
                        end
                    end else if (take && s_axis_tlast) begin
                        r_final <= 1'b1;
                        r_len   <= (r_pos < 6'd56);
                        r_pos   <= r_pos + 6'd1;
                        r_state <= last_byte ? S_LOAD : S_PAD;
                    end
                end
                S_PAD: begin
                    // first pad slot after a final data byte holds 0x80
                    r_pad80 <= 1'b0;
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= S_LOAD;
                end
                S_LOAD: r_state <= S_ROUND;
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'(sha256_pkg::RoundCount - 1)) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_rnd <= '0;
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (r_len) begin
                        r_state  <= S_OUT;
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                    end else begin
                        r_len   <= 1'b1;
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_state  <= S_IDLE;
                            r_final  <= 1'b0;
                            r_len    <= 1'b0;
                            r_pos    <= '0;
                            r_bits   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/sha256_stream_hash_chk.sv
// port-level checks for the sha-256 stream hash
module sha256_stream_hash_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during digest output");
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast not on word 7");
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
        else $error("digest words not consecutive");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("stalled word changed");
endmodule

bind sha256_stream_hash sha256_stream_hash_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
